@@ design/cwsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsc_pkg
// Shared constants, codes and controller/datapath interface types for the
// contact impulse warm start cache.
// ----------------------------------------------------------------------------
package cwsc_pkg;

	localparam int STORE_ENTRIES = 256;
	localparam int STORE_AW      = 8;
	localparam int ACC_ENTRIES   = 64;
	localparam int ACC_AW        = 6;
	localparam int ACC_UW        = 7;
	localparam int KEY_W         = 32;
	localparam int IMP_W         = 32;
	localparam int SUM_W         = 40;
	localparam int CNT_W         = 8;
	localparam int SCALE_W       = 16;
	localparam int DIV_STEPS     = 40;
	localparam int DCNT_W        = 6;
	localparam int STORE_DW      = KEY_W + IMP_W;
	localparam int ACC_DW        = KEY_W + SUM_W + CNT_W;

	localparam logic [CNT_W-1:0]   COUNT_MAX   = 8'd255;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd49152;

	// Byte address of the lookup factor register.
	localparam logic [1:0] ADDR_WARM_SCALE = 2'd0;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ACCUM  = 2'd1,
		OP_COMMIT = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_STORE_FULL = 2'd1,
		ST_ACC_FULL   = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LK_RD,
		S_LK_CMP,
		S_LK_RES,
		S_AC_RD,
		S_AC_CMP,
		S_AC_UPD,
		S_AC_NEW,
		S_CM_RD,
		S_CM_LAT,
		S_CM_DIV,
		S_SS_RD,
		S_SS_CMP,
		S_SS_END,
		S_CM_NEXT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic j_clr;
		logic j_inc;
		logic st_rd;
		logic ac_rd_idx;
		logic ac_rd_j;
		logic lk_mul;
		logic res_hit;
		logic ac_upd;
		logic ac_new;
		logic cm_lat;
		logic div_step;
		logic free_track;
		logic st_wr_match;
		logic st_wr_free;
		logic used_clr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op_in;
		logic       st_match;
		logic       ac_match;
		logic       idx_last_store;
		logic       idx_last_acc;
		logic       j_last;
		logic       acc_empty;
		logic       div_done;
		logic       out_free;
	} stat_t;

endpackage

@@ design/cwsc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cwsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/cwsc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsc_ctrl
// Controller state machine: sequences table searches, updates, the commit
// walk with its divider, and the result hand-off.
// ----------------------------------------------------------------------------
module cwsc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cwsc_pkg::stat_t stat,
	output cwsc_pkg::cmd_t  cmd
);

	cwsc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cwsc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			cwsc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.idx_clr = 1'b1;
					cmd.j_clr   = 1'b1;
					case (stat.op_in)
						cwsc_pkg::OP_LOOKUP: state_d = cwsc_pkg::S_LK_RD;
						cwsc_pkg::OP_ACCUM: begin
							state_d = stat.acc_empty ? cwsc_pkg::S_AC_NEW : cwsc_pkg::S_AC_RD;
						end
						cwsc_pkg::OP_COMMIT: begin
							state_d = stat.acc_empty ? cwsc_pkg::S_DONE : cwsc_pkg::S_CM_RD;
						end
						default: state_d = cwsc_pkg::S_DONE;
					endcase
				end
			end
			cwsc_pkg::S_LK_RD: begin
				cmd.st_rd = 1'b1;
				state_d   = cwsc_pkg::S_LK_CMP;
			end
			cwsc_pkg::S_LK_CMP: begin
				if (stat.st_match) begin
					cmd.lk_mul = 1'b1;
					state_d    = cwsc_pkg::S_LK_RES;
				end else if (stat.idx_last_store) begin
					state_d = cwsc_pkg::S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = cwsc_pkg::S_LK_RD;
				end
			end
			cwsc_pkg::S_LK_RES: begin
				cmd.res_hit = 1'b1;
				state_d     = cwsc_pkg::S_DONE;
			end
			cwsc_pkg::S_AC_RD: begin
				cmd.ac_rd_idx = 1'b1;
				state_d       = cwsc_pkg::S_AC_CMP;
			end
			cwsc_pkg::S_AC_CMP: begin
				if (stat.ac_match) begin
					state_d = cwsc_pkg::S_AC_UPD;
				end else if (stat.idx_last_acc) begin
					state_d = cwsc_pkg::S_AC_NEW;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = cwsc_pkg::S_AC_RD;
				end
			end
			cwsc_pkg::S_AC_UPD: begin
				cmd.ac_upd = 1'b1;
				state_d    = cwsc_pkg::S_DONE;
			end
			cwsc_pkg::S_AC_NEW: begin
				cmd.ac_new = 1'b1;
				state_d    = cwsc_pkg::S_DONE;
			end
			cwsc_pkg::S_CM_RD: begin
				cmd.ac_rd_j = 1'b1;
				state_d     = cwsc_pkg::S_CM_LAT;
			end
			cwsc_pkg::S_CM_LAT: begin
				cmd.cm_lat  = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d     = cwsc_pkg::S_CM_DIV;
			end
			cwsc_pkg::S_CM_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = cwsc_pkg::S_SS_RD;
				end
			end
			cwsc_pkg::S_SS_RD: begin
				cmd.st_rd = 1'b1;
				state_d   = cwsc_pkg::S_SS_CMP;
			end
			cwsc_pkg::S_SS_CMP: begin
				cmd.free_track = 1'b1;
				if (stat.st_match) begin
					cmd.st_wr_match = 1'b1;
					state_d         = cwsc_pkg::S_CM_NEXT;
				end else if (stat.idx_last_store) begin
					state_d = cwsc_pkg::S_SS_END;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = cwsc_pkg::S_SS_RD;
				end
			end
			cwsc_pkg::S_SS_END: begin
				cmd.st_wr_free = 1'b1;
				state_d        = cwsc_pkg::S_CM_NEXT;
			end
			cwsc_pkg::S_CM_NEXT: begin
				if (stat.j_last) begin
					cmd.used_clr = 1'b1;
					state_d      = cwsc_pkg::S_DONE;
				end else begin
					cmd.j_inc = 1'b1;
					state_d   = cwsc_pkg::S_CM_RD;
				end
			end
			cwsc_pkg::S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = cwsc_pkg::S_IDLE;
				end
			end
			default: state_d = cwsc_pkg::S_IDLE;
		endcase
	end

endmodule

@@ design/cwsc_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsc_dpath
// Datapath: store and accumulator memories, search counters, warm-start
// multiplier, serial divider for commit averages, and the result register.
// ----------------------------------------------------------------------------
module cwsc_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    opcode,
	input  logic [15:0]                   body_id_a,
	input  logic [15:0]                   body_id_b,
	input  logic signed [31:0]            impulse_in,
	input  logic [cwsc_pkg::SCALE_W-1:0]  warm_scale,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            impulse_out,
	output logic                          hit,
	output logic [1:0]                    status,
	input  cwsc_pkg::cmd_t                cmd,
	output cwsc_pkg::stat_t               stat
);

	// Item registers.
	logic [cwsc_pkg::KEY_W-1:0]        key_q;
	logic signed [cwsc_pkg::IMP_W-1:0] imp_q;
	logic signed [cwsc_pkg::IMP_W-1:0] res_q;
	logic                              hit_q;
	logic [1:0]                        status_q;

	// Counters and valid bits.
	logic [cwsc_pkg::STORE_AW-1:0]  idx_q;
	logic [cwsc_pkg::ACC_AW-1:0]    j_q;
	logic [cwsc_pkg::ACC_UW-1:0]    used_q;
	logic [cwsc_pkg::STORE_ENTRIES-1:0] st_valid_q;
	logic                           free_found_q;
	logic [cwsc_pkg::STORE_AW-1:0]  free_idx_q;
	logic                           commit_q;

	// Commit entry and divider.
	logic [cwsc_pkg::KEY_W-1:0]   ckey_q;
	logic [cwsc_pkg::SUM_W-1:0]   dq_q;
	logic [cwsc_pkg::CNT_W:0]     rem_q;
	logic [cwsc_pkg::CNT_W-1:0]   den_q;
	logic [cwsc_pkg::DCNT_W-1:0]  dcnt_q;
	logic                         neg_q;
	logic signed [47:0]           prod_q;

	// Output register.
	logic                         out_valid_q;
	logic signed [31:0]           out_imp_q;
	logic                         out_hit_q;
	logic [1:0]                   out_status_q;

	// Memory ports.
	logic                          st_we;
	logic [cwsc_pkg::STORE_AW-1:0] st_waddr;
	logic [cwsc_pkg::STORE_DW-1:0] st_wdata, st_rdata;
	logic                          ac_we, ac_re;
	logic [cwsc_pkg::ACC_AW-1:0]   ac_waddr, ac_raddr;
	logic [cwsc_pkg::ACC_DW-1:0]   ac_wdata, ac_rdata;

	logic [cwsc_pkg::KEY_W-1:0]        st_rd_key;
	logic signed [cwsc_pkg::IMP_W-1:0] st_rd_imp;
	logic [cwsc_pkg::KEY_W-1:0]        ac_rd_key;
	logic signed [cwsc_pkg::SUM_W-1:0] ac_rd_sum;
	logic [cwsc_pkg::CNT_W-1:0]        ac_rd_cnt;

	logic [cwsc_pkg::KEY_W-1:0]        key_in;
	logic signed [cwsc_pkg::SUM_W-1:0] imp_ext, sum_abs;
	logic signed [48:0]                prod_full;
	logic [cwsc_pkg::CNT_W:0]          div_shift;
	logic                              div_bit;
	logic [cwsc_pkg::SUM_W-1:0]        quot_signed;
	logic                              cur_valid;

	assign key_in = (body_id_a < body_id_b) ? {body_id_a, body_id_b} : {body_id_b, body_id_a};
	assign imp_ext = cwsc_pkg::SUM_W'(imp_q);

	assign {st_rd_key, st_rd_imp}           = st_rdata;
	assign {ac_rd_key, ac_rd_sum, ac_rd_cnt} = ac_rdata;
	assign cur_valid = st_valid_q[idx_q];

	assign prod_full = st_rd_imp * $signed({1'b0, warm_scale});
	assign sum_abs   = ac_rd_sum[cwsc_pkg::SUM_W-1] ? -ac_rd_sum : ac_rd_sum;

	assign div_shift   = {rem_q[cwsc_pkg::CNT_W-1:0], dq_q[cwsc_pkg::SUM_W-1]};
	assign div_bit     = div_shift >= {1'b0, den_q};
	assign quot_signed = neg_q ? -dq_q : dq_q;

	// Store memory: at most one write per committed pair, a registered read during searches.
	assign st_we    = cmd.st_wr_match | (cmd.st_wr_free & free_found_q);
	assign st_waddr = cmd.st_wr_match ? idx_q : free_idx_q;
	assign st_wdata = {ckey_q, quot_signed[cwsc_pkg::IMP_W-1:0]};

	cwsc_ram #(.WIDTH(cwsc_pkg::STORE_DW), .DEPTH(cwsc_pkg::STORE_ENTRIES)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (cmd.st_rd),
		.raddr (idx_q),
		.rdata (st_rdata)
	);

	assign ac_re    = cmd.ac_rd_idx | cmd.ac_rd_j;
	assign ac_raddr = cmd.ac_rd_j ? j_q : idx_q[cwsc_pkg::ACC_AW-1:0];
	assign ac_we    = (cmd.ac_upd && ac_rd_cnt < cwsc_pkg::COUNT_MAX) ||
	                  (cmd.ac_new && used_q != cwsc_pkg::ACC_UW'(cwsc_pkg::ACC_ENTRIES));
	assign ac_waddr = cmd.ac_upd ? idx_q[cwsc_pkg::ACC_AW-1:0] :
	                  used_q[cwsc_pkg::ACC_AW-1:0];
	assign ac_wdata = cmd.ac_upd ?
	                  {key_q, ac_rd_sum + imp_ext, ac_rd_cnt + cwsc_pkg::CNT_W'(1)} :
	                  {key_q, imp_ext, cwsc_pkg::CNT_W'(1)};

	cwsc_ram #(.WIDTH(cwsc_pkg::ACC_DW), .DEPTH(cwsc_pkg::ACC_ENTRIES)) u_acc (
		.clk   (clk),
		.we    (ac_we),
		.waddr (ac_waddr),
		.wdata (ac_wdata),
		.re    (ac_re),
		.raddr (ac_raddr),
		.rdata (ac_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			j_q          <= '0;
			used_q       <= '0;
			st_valid_q   <= '0;
			free_found_q <= 1'b0;
			commit_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			dcnt_q       <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + cwsc_pkg::STORE_AW'(1);
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + cwsc_pkg::ACC_AW'(1);
			end
			if (cmd.used_clr) begin
				used_q <= '0;
			end else if (cmd.ac_new && ac_we) begin
				used_q <= used_q + cwsc_pkg::ACC_UW'(1);
			end
			if (st_we) begin
				st_valid_q[st_waddr] <= 1'b1;
			end
			// The store scan compares against the commit key once a commit
			// has latched its first entry.
			if (cmd.load) begin
				commit_q <= 1'b0;
			end else if (cmd.cm_lat) begin
				commit_q <= 1'b1;
			end
			// The lowest invalid slot seen so far in this store scan.
			if (cmd.cm_lat) begin
				free_found_q <= 1'b0;
			end else if (cmd.free_track && !cur_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (cmd.cm_lat) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + cwsc_pkg::DCNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= key_in;
			imp_q    <= impulse_in;
			res_q    <= impulse_in;
			hit_q    <= 1'b0;
			status_q <= cwsc_pkg::ST_OK;
		end else if (cmd.res_hit) begin
			res_q <= prod_q[47:16];
			hit_q <= 1'b1;
		end else if (cmd.ac_new && !ac_we) begin
			status_q <= cwsc_pkg::ST_ACC_FULL;
		end else if (cmd.st_wr_free && !free_found_q) begin
			status_q <= cwsc_pkg::ST_STORE_FULL;
		end
		if (cmd.lk_mul) begin
			prod_q <= prod_full[47:0];
		end
		if (cmd.free_track && !cur_valid && !free_found_q) begin
			free_idx_q <= idx_q;
		end
		if (cmd.cm_lat) begin
			ckey_q <= ac_rd_key;
			dq_q   <= sum_abs;
			neg_q  <= ac_rd_sum[cwsc_pkg::SUM_W-1];
			den_q  <= (ac_rd_cnt == '0) ? cwsc_pkg::CNT_W'(1) : ac_rd_cnt;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_bit ? (div_shift - {1'b0, den_q}) : div_shift;
			dq_q  <= {dq_q[cwsc_pkg::SUM_W-2:0], div_bit};
		end
		if (cmd.out_load) begin
			out_imp_q    <= res_q;
			out_hit_q    <= hit_q;
			out_status_q <= status_q;
		end
	end

	assign stat.op_in          = opcode;
	assign stat.st_match       = cur_valid && (st_rd_key == (commit_q ? ckey_q : key_q));
	assign stat.ac_match       = ac_rd_key == key_q;
	assign stat.idx_last_store = idx_q == cwsc_pkg::STORE_AW'(cwsc_pkg::STORE_ENTRIES - 1);
	assign stat.idx_last_acc   = {1'b0, idx_q[cwsc_pkg::ACC_AW-1:0]} ==
	                             used_q - cwsc_pkg::ACC_UW'(1);
	assign stat.j_last         = {1'b0, j_q} == used_q - cwsc_pkg::ACC_UW'(1);
	assign stat.acc_empty      = used_q == '0;
	assign stat.div_done       = dcnt_q == cwsc_pkg::DCNT_W'(cwsc_pkg::DIV_STEPS - 1);
	assign stat.out_free       = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign impulse_out = out_imp_q;
	assign hit         = out_hit_q;
	assign status      = out_status_q;

endmodule

@@ design/contact_impulse_warm_start_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_impulse_warm_start_cache
// Warm-start impulse cache keyed by an unordered body pair, with a per-frame
// accumulator and a commit that averages into the store.
// ----------------------------------------------------------------------------
// One transaction at a time is processed. A transaction is accepted in the
// idle state, in the cycle after the previous result was loaded into the
// output register. A lookup scans the 256-entry store one entry at a time,
// a read and then a compare for each, and stops at the first matching slot
// or after the last entry on a miss. An accumulate scans the used
// accumulator entries in the same way and stops at a match, or appends a new
// pair after the last used entry. A commit, for each accumulated pair,
// fetches it, runs a serial divide and scans the store for the pair or a
// free slot, then clears the accumulator at the end. The store search runs
// through its single read port. A new transaction is accepted while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
module contact_impulse_warm_start_cache (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [15:0]        body_id_a,
	input  logic [15:0]        body_id_b,
	input  logic signed [31:0] impulse_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] impulse_out,
	output logic               hit,
	output logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [cwsc_pkg::SCALE_W-1:0] warm_scale_q;
	cwsc_pkg::cmd_t               cmd;
	cwsc_pkg::stat_t              stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_scale_q <= cwsc_pkg::SCALE_RESET;
		end else if (psel && penable && pwrite && paddr == cwsc_pkg::ADDR_WARM_SCALE) begin
			warm_scale_q <= pwdata[cwsc_pkg::SCALE_W-1:0];
		end
	end

	assign prdata = (paddr == cwsc_pkg::ADDR_WARM_SCALE) ? {16'd0, warm_scale_q} : 32'd0;

	cwsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cwsc_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (opcode),
		.body_id_a   (body_id_a),
		.body_id_b   (body_id_b),
		.impulse_in  (impulse_in),
		.warm_scale  (warm_scale_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.impulse_out (impulse_out),
		.hit         (hit),
		.status      (status),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

@@ tb/tb_contact_impulse_warm_start_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contact_impulse_warm_start_cache
// Self-checking testbench: a directed table of lookups, accumulates and
// commits, then random traffic over a small pool of body pairs plus sequences
// that saturate a count, fill the accumulator and fill the store. Each result
// is checked against an in-bench model of the cache or against the value typed in the table.
// ----------------------------------------------------------------------------
module tb_contact_impulse_warm_start_cache;

	localparam int LIMIT     = 8000000;
	localparam int POOL_SIZE = 20;

	typedef struct {
		logic signed [31:0] imp;
		logic               hit;
		cwsc_pkg::status_t  st;
	} result_t;

	typedef struct {
		cwsc_pkg::opcode_t op;
		logic [15:0]       a;
		logic [15:0]       b;
		logic [31:0]       imp;
		bit                typed;
		logic [31:0]       e_imp;
		bit                e_hit;
		cwsc_pkg::status_t e_st;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode = '0;
	logic [15:0]        body_id_a = '0;
	logic [15:0]        body_id_b = '0;
	logic signed [31:0] impulse_in = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] impulse_out;
	logic               hit;
	logic [1:0]         status;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [1:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// Model of the cache contents.
	logic [15:0]        scale_m;
	logic [31:0]        st_key [cwsc_pkg::STORE_ENTRIES];
	logic signed [31:0] st_imp [cwsc_pkg::STORE_ENTRIES];
	bit                 st_val [cwsc_pkg::STORE_ENTRIES];
	logic [31:0]        ac_key [cwsc_pkg::ACC_ENTRIES];
	longint             ac_sum [cwsc_pkg::ACC_ENTRIES];
	int                 ac_cnt [cwsc_pkg::ACC_ENTRIES];
	int                 ac_used;

	result_t     expected_results[$];
	int          errors = 0;
	int          cycles = 0;
	int          in_idle = 0;
	int          out_idle = 0;
	bit          typed_pending = 1'b0;
	result_t     typed_res;
	logic [15:0] pool_a [POOL_SIZE];
	logic [15:0] pool_b [POOL_SIZE];

	row_t plan[16] = '{
		'{cwsc_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000, 32'h80000000, 1, 32'h80000000, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_NONE,   16'h0001, 16'h0002, 32'h12345678, 1, 32'h12345678, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_ACCUM,  16'h0005, 16'h0003, 32'h00010000, 1, 32'h00010000, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_ACCUM,  16'h0003, 16'h0005, 32'h00030000, 1, 32'h00030000, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_ACCUM,  16'hFFFF, 16'hFFFF, 32'h80000000, 1, 32'h80000000, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_ACCUM,  16'h0000, 16'hFFFF, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_COMMIT, 16'h0000, 16'h0000, 32'h00000000, 1, 32'h00000000, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_LOOKUP, 16'h0005, 16'h0003, 32'h00000000, 1, 32'h00018000, 1,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_LOOKUP, 16'hFFFF, 16'hFFFF, 32'h00000001, 1, 32'hA0000000, 1,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000, 32'h00000001, 0, 32'h0, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_ACCUM,  16'h0005, 16'h0003, 32'hFFFFFFFF, 0, 32'h0, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_ACCUM,  16'h0003, 16'h0005, 32'hFFFFFFFE, 0, 32'h0, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_COMMIT, 16'h1234, 16'h4321, 32'h00000005, 0, 32'h0, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_LOOKUP, 16'h0003, 16'h0005, 32'h00000000, 0, 32'h0, 0,
			cwsc_pkg::ST_OK},
		'{cwsc_pkg::OP_COMMIT, 16'h0000, 16'h0000, 32'h00000000, 0, 32'h0, 0,
			cwsc_pkg::ST_OK}
	};

	contact_impulse_warm_start_cache DUT (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int store_lookup(logic [31:0] key);
		for (int i = 0; i < cwsc_pkg::STORE_ENTRIES; i++)
			if (st_val[i] && st_key[i] == key)
				return i;
		return -1;
	endfunction

	// Computes the result of one transaction and updates the model state.
	task automatic predict_cache(input logic [1:0] op, input logic [15:0] a,
			input logic [15:0] b, input logic signed [31:0] imp, output result_t r);
		logic [31:0]        key;
		logic signed [63:0] prod;
		int                 idx;
		longint             avg;
		key = (a < b) ? {a, b} : {b, a};
		r.imp = imp;
		r.hit = 1'b0;
		r.st = cwsc_pkg::ST_OK;
		case (op)
			cwsc_pkg::OP_LOOKUP: begin
				idx = store_lookup(key);
				if (idx >= 0) begin
					prod = 64'(st_imp[idx]) * $signed({48'd0, scale_m});
					r.imp = 32'(prod >>> 16);
					r.hit = 1'b1;
				end
			end
			cwsc_pkg::OP_ACCUM: begin
				idx = -1;
				for (int i = 0; i < ac_used; i++)
					if (idx < 0 && ac_key[i] == key)
						idx = i;
				if (idx >= 0) begin
					if (ac_cnt[idx] < 255) begin
						ac_sum[idx] += longint'(imp);
						ac_cnt[idx]++;
					end
				end else if (ac_used < cwsc_pkg::ACC_ENTRIES) begin
					ac_key[ac_used] = key;
					ac_sum[ac_used] = longint'(imp);
					ac_cnt[ac_used] = 1;
					ac_used++;
				end else begin
					r.st = cwsc_pkg::ST_ACC_FULL;
				end
			end
			cwsc_pkg::OP_COMMIT: begin
				for (int i = 0; i < ac_used; i++) begin
					avg = ac_sum[i] / longint'(ac_cnt[i]);
					idx = store_lookup(ac_key[i]);
					if (idx < 0) begin
						for (int j = cwsc_pkg::STORE_ENTRIES - 1; j >= 0; j--)
							if (!st_val[j])
								idx = j;
						if (idx >= 0) begin
							st_val[idx] = 1'b1;
							st_key[idx] = ac_key[i];
						end
					end
					if (idx >= 0)
						st_imp[idx] = 32'(avg);
					else
						r.st = cwsc_pkg::ST_STORE_FULL;
				end
				ac_used = 0;
			end
			default: ;
		endcase
	endtask

	// Accepted transactions on the input side feed the model.
	always @(posedge clk) begin
		result_t r;
		if (arst_n && in_valid && in_ready) begin
			predict_cache(opcode, body_id_a, body_id_b, impulse_in, r);
			expected_results.push_back(typed_pending ? typed_res : r);
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t e;
		out_ready <= ($urandom_range(99) >= out_idle);
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", impulse_out, 32'h0);
			end else begin
				e = expected_results.pop_front();
				if (impulse_out !== e.imp)
					report_mismatch("impulse_out", impulse_out, e.imp);
				if (hit !== e.hit)
					report_mismatch("hit", {31'd0, hit}, {31'd0, e.hit});
				if (status !== e.st)
					report_mismatch("status", {30'd0, status}, {30'd0, e.st});
			end
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [15:0] a,
			input logic [15:0] b, input logic [31:0] imp, input bit typed,
			input result_t tr);
		if ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < in_idle);
		end
		in_valid <= 1'b1;
		opcode <= op;
		body_id_a <= a;
		body_id_b <= b;
		impulse_in <= imp;
		typed_pending <= typed;
		typed_res <= tr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_plain(input logic [1:0] op, input logic [15:0] a,
			input logic [15:0] b, input logic [31:0] imp);
		result_t none;
		none = '{0, 0, cwsc_pkg::ST_OK};
		send_item(op, a, b, imp, 1'b0, none);
	endtask

	// Waits until every result is back, then rewrites the lookup factor.
	task automatic write_scale(input logic [15:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= cwsc_pkg::ADDR_WARM_SCALE;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		scale_m = value;
	endtask

	function automatic logic [31:0] pick_impulse();
		case ($urandom_range(9))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return 32'hFFFFFFFF;
			3: return 32'h00000000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_item();
		int          r;
		int          k;
		logic [15:0] a;
		logic [15:0] b;
		r = $urandom_range(99);
		k = $urandom_range(POOL_SIZE - 1);
		a = pool_a[k];
		b = pool_b[k];
		if ($urandom_range(1)) begin
			a = pool_b[k];
			b = pool_a[k];
		end
		if (r < 5) begin
			// A lookup of an arbitrary pair almost always misses.
			a = 16'($urandom);
			b = 16'($urandom);
		end
		if (r < 50)
			send_plain(cwsc_pkg::OP_LOOKUP, a, b, pick_impulse());
		else if (r < 90)
			send_plain(cwsc_pkg::OP_ACCUM, a, b, pick_impulse());
		else if (r < 97)
			send_plain(cwsc_pkg::OP_COMMIT, 16'($urandom), 16'($urandom), pick_impulse());
		else
			send_plain(cwsc_pkg::OP_NONE, 16'($urandom), 16'($urandom), pick_impulse());
	endtask

	initial begin
		result_t tr;
		logic [15:0] a;
		scale_m = cwsc_pkg::SCALE_RESET;
		ac_used = 0;
		foreach (st_val[i])
			st_val[i] = 1'b0;
		foreach (pool_a[i]) begin
			pool_a[i] = 16'($urandom);
			pool_b[i] = 16'($urandom);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			tr = '{plan[i].e_imp, plan[i].e_hit, plan[i].e_st};
			send_item(plan[i].op, plan[i].a, plan[i].b, plan[i].imp, plan[i].typed, tr);
		end

		write_scale(16'hFFFF);
		in_idle = 10;
		out_idle = 75;
		repeat (450) random_item();

		write_scale(16'h0000);
		in_idle = 75;
		out_idle = 10;
		repeat (450) random_item();

		write_scale(16'($urandom));
		in_idle = 0;
		out_idle = 0;
		send_plain(cwsc_pkg::OP_COMMIT, 16'd0, 16'd0, 32'd0);
		// One pair past the count limit, then the accumulator filled to overflow.
		a = 16'($urandom);
		repeat (260) send_plain(cwsc_pkg::OP_ACCUM, a, 16'h00FF, pick_impulse());
		send_plain(cwsc_pkg::OP_COMMIT, 16'd0, 16'd0, 32'd0);
		send_plain(cwsc_pkg::OP_LOOKUP, 16'h00FF, a, 32'd0);
		for (int i = 0; i < cwsc_pkg::ACC_ENTRIES + 2; i++)
			send_plain(cwsc_pkg::OP_ACCUM, 16'($urandom), 16'($urandom), $urandom);
		send_plain(cwsc_pkg::OP_COMMIT, 16'd0, 16'd0, 32'd0);

		// Enough distinct pairs to run the store out of free slots.
		write_scale(16'd1);
		for (int f = 0; f < 5; f++) begin
			for (int i = 0; i < cwsc_pkg::ACC_ENTRIES; i++)
				send_plain(cwsc_pkg::OP_ACCUM, 16'($urandom), 16'($urandom), $urandom);
			send_plain(cwsc_pkg::OP_COMMIT, 16'd0, 16'd0, 32'd0);
		end
		write_scale(cwsc_pkg::SCALE_RESET);
		repeat (30) random_item();

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
